FILE: rtl/core/tcpcq_pkg.sv
// Types and constants shared by the three-class priority call queue.
package tcpcq_pkg;

    localparam int unsigned CALLER_W   = 32;
    localparam int unsigned RECEIVER_W = 32;
    localparam int unsigned PACKETS_W  = 16;

    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 88;
    localparam int unsigned M_TUSER_W = 2;

    typedef enum logic [2:0] {
        FUNC_ADD_DATA  = 3'd0,
        FUNC_ADD_VOICE = 3'd1,
        FUNC_ADD_EMRG  = 3'd2,
        FUNC_SERVE     = 3'd3,
        FUNC_DISMISS   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_EMRG  = 2'd1,
        CLASS_VOICE = 2'd2,
        CLASS_DATA  = 2'd3
    } class_t;

    localparam logic [1:0] Q_EMRG  = 2'd0;
    localparam logic [1:0] Q_VOICE = 2'd1;
    localparam logic [1:0] Q_DATA  = 2'd2;

    typedef struct packed {
        logic [CALLER_W-1:0]   caller;
        logic [RECEIVER_W-1:0] receiver;
    } emrg_entry_t;

    typedef struct packed {
        logic [CALLER_W-1:0]   caller;
        logic [RECEIVER_W-1:0] receiver;
        logic                  roaming;
        logic                  show;
    } voice_entry_t;

    typedef struct packed {
        logic [CALLER_W-1:0]   caller;
        logic [RECEIVER_W-1:0] receiver;
        logic [PACKETS_W-1:0]  packets;
    } data_entry_t;

endpackage

FILE: rtl/core/three_class_priority_call_queue.sv
// Three-class strict-priority call queue: top level.
//
// Holds emergency, voice and data calls in three circular queues of QUEUE_DEPTH
// entries, one single-port memory per class. Each request (add, serve or
// dismiss, selected on s_tuser) gives exactly one result. One request is taken
// every cycle while results drain; a result is valid once its request has passed
// through the input register and its queue memory read has landed in the result
// register. A result held by m_tready stalls the input once the input register
// is also full, so two requests are in flight at most. A serve pops the
// emergency queue first, then voice, then
// data; m_tuser gives the class served, none when all are empty. An add to a
// full queue is refused and flagged in the dropped bit. Dismiss empties the
// data queue, or the voice queue when data is empty. No clearing pass after
// reset: the block takes requests from the first cycle.
module three_class_priority_call_queue
    import tcpcq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] caller_id, [63:32] receiver_id, [79:64] packet_number,
    // [80] show_caller, [81] roaming, [87:82] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] func
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] served_caller, [32] caller_hidden, [64:33] served_receiver,
    // [80:65] served_packets, [81] served_roaming, [82] dropped, [87:83] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [1:0] served_class
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    // Input register
    logic                  in_valid_reg;
    logic [2:0]            func_reg;
    logic [CALLER_W-1:0]   caller_reg;
    logic [RECEIVER_W-1:0] receiver_reg;
    logic [PACKETS_W-1:0]  packets_reg;
    logic                  show_reg;
    logic                  roaming_reg;

    // Queue control
    logic [PTR_W-1:0] heads_reg [3];
    logic [PTR_W-1:0] heads_next [3];
    logic [CNT_W-1:0] counts_reg [3];
    logic [CNT_W-1:0] counts_next [3];
    logic [PTR_W-1:0] tail [3];
    logic [SUM_W-1:0] tail_sum [3];

    // Result register
    logic         out_valid_reg;
    class_t       class_reg;
    class_t       class_next;
    logic         dropped_reg;
    logic         dropped_next;
    emrg_entry_t  e_rd_reg;
    voice_entry_t v_rd_reg;
    data_entry_t  d_rd_reg;

    // Memories
    emrg_entry_t  emrg_mem  [QUEUE_DEPTH];
    voice_entry_t voice_mem [QUEUE_DEPTH];
    data_entry_t  data_mem  [QUEUE_DEPTH];

    logic e_wr, v_wr, d_wr;
    logic e_rd, v_rd, d_rd;

    logic advance;
    logic exec;
    logic s_accept;

    logic [CALLER_W-1:0]   served_caller;
    logic                  caller_hidden;
    logic [RECEIVER_W-1:0] served_receiver;
    logic [PACKETS_W-1:0]  served_packets;
    logic                  served_roaming;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == LAST_PTR) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign advance  = !out_valid_reg || m_tready;
    assign exec     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (exec) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg     <= s_tuser[2:0];
            caller_reg   <= s_tdata[31:0];
            receiver_reg <= s_tdata[63:32];
            packets_reg  <= s_tdata[79:64];
            show_reg     <= s_tdata[80];
            roaming_reg  <= s_tdata[81];
        end
    end

    always_comb begin
        for (int q = 0; q < 3; q++) begin
            tail_sum[q] = SUM_W'(heads_reg[q]) + SUM_W'(counts_reg[q]);
            if (tail_sum[q] >= DEPTH_SUM) begin
                tail_sum[q] = tail_sum[q] - DEPTH_SUM;
            end
            tail[q] = tail_sum[q][PTR_W-1:0];
        end
    end

    always_comb begin
        heads_next   = heads_reg;
        counts_next  = counts_reg;
        class_next   = CLASS_NONE;
        dropped_next = 1'b0;
        e_wr = 1'b0;
        v_wr = 1'b0;
        d_wr = 1'b0;
        e_rd = 1'b0;
        v_rd = 1'b0;
        d_rd = 1'b0;
        if (exec) begin
            case (func_reg)
                FUNC_ADD_DATA: begin
                    if (counts_reg[Q_DATA] == DEPTH_CNT) begin
                        dropped_next = 1'b1;
                    end else begin
                        d_wr = 1'b1;
                        counts_next[Q_DATA] = counts_reg[Q_DATA] + CNT_W'(1);
                    end
                end
                FUNC_ADD_VOICE: begin
                    if (counts_reg[Q_VOICE] == DEPTH_CNT) begin
                        dropped_next = 1'b1;
                    end else begin
                        v_wr = 1'b1;
                        counts_next[Q_VOICE] = counts_reg[Q_VOICE] + CNT_W'(1);
                    end
                end
                FUNC_ADD_EMRG: begin
                    if (counts_reg[Q_EMRG] == DEPTH_CNT) begin
                        dropped_next = 1'b1;
                    end else begin
                        e_wr = 1'b1;
                        counts_next[Q_EMRG] = counts_reg[Q_EMRG] + CNT_W'(1);
                    end
                end
                FUNC_SERVE: begin
                    if (counts_reg[Q_EMRG] != '0) begin
                        e_rd = 1'b1;
                        class_next = CLASS_EMRG;
                        heads_next[Q_EMRG]  = next_ptr(heads_reg[Q_EMRG]);
                        counts_next[Q_EMRG] = counts_reg[Q_EMRG] - CNT_W'(1);
                    end else if (counts_reg[Q_VOICE] != '0) begin
                        v_rd = 1'b1;
                        class_next = CLASS_VOICE;
                        heads_next[Q_VOICE]  = next_ptr(heads_reg[Q_VOICE]);
                        counts_next[Q_VOICE] = counts_reg[Q_VOICE] - CNT_W'(1);
                    end else if (counts_reg[Q_DATA] != '0) begin
                        d_rd = 1'b1;
                        class_next = CLASS_DATA;
                        heads_next[Q_DATA]  = next_ptr(heads_reg[Q_DATA]);
                        counts_next[Q_DATA] = counts_reg[Q_DATA] - CNT_W'(1);
                    end
                end
                FUNC_DISMISS: begin
                    if (counts_reg[Q_DATA] != '0) begin
                        heads_next[Q_DATA]  = '0;
                        counts_next[Q_DATA] = '0;
                    end else if (counts_reg[Q_VOICE] != '0) begin
                        heads_next[Q_VOICE]  = '0;
                        counts_next[Q_VOICE] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < 3; q++) begin
                heads_reg[q]  <= '0;
                counts_reg[q] <= '0;
            end
            out_valid_reg <= 1'b0;
            class_reg     <= CLASS_NONE;
            dropped_reg   <= 1'b0;
        end else begin
            heads_reg  <= heads_next;
            counts_reg <= counts_next;
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                class_reg     <= class_next;
                dropped_reg   <= dropped_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_wr) begin
            emrg_mem[tail[Q_EMRG]] <= '{caller: caller_reg, receiver: receiver_reg};
        end
        if (e_rd) begin
            e_rd_reg <= emrg_mem[heads_reg[Q_EMRG]];
        end
    end

    always_ff @(posedge aclk) begin
        if (v_wr) begin
            voice_mem[tail[Q_VOICE]] <= '{caller: caller_reg, receiver: receiver_reg,
                                          roaming: roaming_reg, show: show_reg};
        end
        if (v_rd) begin
            v_rd_reg <= voice_mem[heads_reg[Q_VOICE]];
        end
    end

    always_ff @(posedge aclk) begin
        if (d_wr) begin
            data_mem[tail[Q_DATA]] <= '{caller: caller_reg, receiver: receiver_reg,
                                        packets: packets_reg};
        end
        if (d_rd) begin
            d_rd_reg <= data_mem[heads_reg[Q_DATA]];
        end
    end

    always_comb begin
        served_caller   = '0;
        caller_hidden   = 1'b0;
        served_receiver = '0;
        served_packets  = '0;
        served_roaming  = 1'b0;
        case (class_reg)
            CLASS_EMRG: begin
                served_caller   = e_rd_reg.caller;
                served_receiver = e_rd_reg.receiver;
            end
            CLASS_VOICE: begin
                served_caller   = v_rd_reg.show ? v_rd_reg.caller : '0;
                caller_hidden   = !v_rd_reg.show;
                served_receiver = v_rd_reg.receiver;
                served_roaming  = v_rd_reg.roaming;
            end
            CLASS_DATA: begin
                served_caller   = d_rd_reg.caller;
                served_receiver = d_rd_reg.receiver;
                served_packets  = d_rd_reg.packets;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = class_reg;
    assign m_tdata  = {5'b0, dropped_reg, served_roaming, served_packets,
                       served_receiver, caller_hidden, served_caller};

`ifndef SYNTHESIS
    a_counts_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (counts_reg[Q_EMRG] <= DEPTH_CNT) && (counts_reg[Q_VOICE] <= DEPTH_CNT)
        && (counts_reg[Q_DATA] <= DEPTH_CNT))
        else $error("queue count beyond depth");

    a_heads_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (heads_reg[Q_EMRG] <= LAST_PTR) && (heads_reg[Q_VOICE] <= LAST_PTR)
        && (heads_reg[Q_DATA] <= LAST_PTR))
        else $error("queue head beyond depth");

    a_dropped_no_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && dropped_reg) |-> (class_reg == CLASS_NONE))
        else $error("refused add reports a served class");

    a_emrg_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && (func_reg == FUNC_SERVE) && (counts_reg[Q_EMRG] != '0))
        |=> (class_reg == CLASS_EMRG))
        else $error("serve skipped a waiting emergency call");

    a_dismiss_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && (func_reg == FUNC_DISMISS) && (counts_reg[Q_DATA] != '0))
        |=> (counts_reg[Q_DATA] == '0) && $stable(counts_reg[Q_VOICE]))
        else $error("dismiss did not empty the data queue alone");
`endif

endmodule
